// ===== design/pmdp_pkg.sv =====
`default_nettype none
package pmdp_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned COL_W  = 4;
  localparam int unsigned PHASE_W = 3;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CHAN_W-1:0] CHAN_THRESH  = 8'd128;
  localparam logic [CHAN_W-1:0] ORANGE_GREEN = 8'd224;
  localparam logic [7:0]        MASK_INIT    = 8'hff;
  localparam logic [7:0]        DATA_INIT    = 8'h00;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd7;

  localparam logic [COL_W-1:0] COL_YELLOW = 4'd6;
  localparam logic [COL_W-1:0] COL_ORANGE = 4'd8;

  localparam int unsigned NUM_COLOURS = 9;
  localparam logic [COL_W-1:0] PALETTE_MAP [NUM_COLOURS] = '{
    4'd0, 4'd3, 4'd1, 4'd6, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
  };

  typedef struct packed {
    logic              row_last;
    logic              inside_image;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  function automatic logic [COL_W-1:0] palette_lookup(input logic [COL_W-1:0] col);
    logic [COL_W-1:0] res;
    res = '0;
    for (int i = 0; i < NUM_COLOURS; i++) begin
      if (col == COL_W'(i)) begin
        res = PALETTE_MAP[i];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/pixel_mask_data_packer_top.sv =====
// Channel   Dir  Fields (tdata from bit 0 up)                          Side info
// s_*       in   red[7:0] green[15:8] blue[23:16] inside_image[24]     tlast = row_last
// m_*       out  mask_byte[7:0] data_byte[15:8]                        tlast = row_end
// cfg_*     in   start_shift[2:0]                                      write strobe
//
// One pixel per clock sustained while the output is not held.
// Input register, then color decode and shift update into the output register.
// rst is synchronous: shift bytes to defaults, phase to 0, start_shift to 0.
// A held output stalls the pixel in the input register, which drops s_tready.
`default_nettype none
module pixel_mask_data_packer_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [pmdp_pkg::PHASE_W-1:0]        cfg_wr_data,    // start_shift
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [pmdp_pkg::IN_TDATA_W-1:0]     s_tdata,  // red, green, blue, inside_image
  input  wire logic                                s_tlast,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [pmdp_pkg::OUT_TDATA_W-1:0]         m_tdata,  // mask_byte, data_byte
  output logic                                     m_tlast
);
  import pmdp_pkg::*;

  logic                advance;
  logic                pix_valid;
  pixel_t              pix;
  logic [IDX_W-1:0]    idx;

  pmdp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .advance   (advance),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  pmdp_index u_idx (
    .pix (pix),
    .idx (idx)
  );

  pmdp_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pix_valid   (pix_valid),
    .row_last    (pix.row_last),
    .idx         (idx),
    .advance     (advance),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
`default_nettype wire

// ===== design/pmdp_in_stage.sv =====
`default_nettype none
module pmdp_in_stage (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [pmdp_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire logic                                s_tlast,
  input  wire logic                                advance,
  output logic                                     pix_valid,
  output pmdp_pkg::pixel_t                         pix
);
  import pmdp_pkg::*;

  assign s_tready = !pix_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tready) begin
      pix_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix.red          <= s_tdata[7:0];
      pix.green        <= s_tdata[15:8];
      pix.blue         <= s_tdata[23:16];
      pix.inside_image <= s_tdata[24];
      pix.row_last     <= s_tlast;
    end
  end

endmodule
`default_nettype wire

// ===== design/pmdp_index.sv =====
`default_nettype none
module pmdp_index (
  input  pmdp_pkg::pixel_t               pix,
  output logic [pmdp_pkg::IDX_W-1:0]     idx
);
  import pmdp_pkg::*;

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] mapped;

  always_comb begin
    col = {1'b0, pix.red >= CHAN_THRESH, pix.green >= CHAN_THRESH,
           pix.blue >= CHAN_THRESH};
    if (col == COL_YELLOW && pix.green < ORANGE_GREEN) begin
      col = COL_ORANGE;
    end
    mapped = palette_lookup(col);
    if (!pix.inside_image || mapped == '0) begin
      idx = '0;
    end else begin
      idx = IDX_W'(mapped - 4'd1);
    end
  end

endmodule
`default_nettype wire

// ===== design/pmdp_pack.sv =====
`default_nettype none
module pmdp_pack (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [pmdp_pkg::PHASE_W-1:0]         cfg_wr_data,
  input  wire logic                                 pix_valid,
  input  wire logic                                 row_last,
  input  wire logic [pmdp_pkg::IDX_W-1:0]           idx,
  output logic                                      advance,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [pmdp_pkg::OUT_TDATA_W-1:0]          m_tdata,
  output logic                                      m_tlast
);
  import pmdp_pkg::*;

  logic [PHASE_W-1:0] start_shift;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [7:0]         mask_shift, mask_shift_next;
  logic [7:0]         data_shift, data_shift_next;

  logic               pix_bit;
  logic [7:0]         mask_sh, data_sh;
  logic [PHASE_W-1:0] pad;
  logic               emit;
  logic [7:0]         mask_out, data_out;

  assign advance = pix_valid && (!m_tvalid || m_tready);

  always_comb begin
    pix_bit = phase[0] ? idx[0] : idx[1];
    mask_sh = {mask_shift[6:0], 1'b0};
    data_sh = {data_shift[6:0], pix_bit};
    pad     = PHASE_LAST - phase;
    emit    = (phase == PHASE_LAST) || row_last;

    mask_out = mask_sh;
    data_out = data_sh;
    if (phase != PHASE_LAST) begin
      // pad a partial byte at row end
      mask_out = (mask_sh << pad) | ~(MASK_INIT << pad);
      data_out = data_sh << pad;
    end

    if (row_last) begin
      phase_next      = start_shift;
      mask_shift_next = MASK_INIT;
      data_shift_next = DATA_INIT;
    end else begin
      phase_next      = phase + 3'd1;
      mask_shift_next = mask_sh;
      data_shift_next = data_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_shift <= '0;
    end else if (cfg_wr_en) begin
      start_shift <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      mask_shift <= MASK_INIT;
      data_shift <= DATA_INIT;
    end else if (advance) begin
      phase      <= phase_next;
      mask_shift <= mask_shift_next;
      data_shift <= data_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= {data_out, mask_out};
      m_tlast <= row_last;
    end
  end

endmodule
`default_nettype wire

// ===== design/pmdp_checker.sv =====
`default_nettype none
module pmdp_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [pmdp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input wire logic                                m_tlast
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear pipeline");

  // padded or shifted-in positions never carry data
  a_mask_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] & m_tdata[15:8]) == 8'h00)
    else $error("data bit set under mask");

  // a mid-row byte ends on a real pixel
  a_midrow_mask: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[0])
    else $error("mid-row byte has padded last bit");

endmodule

bind pixel_mask_data_packer_top pmdp_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import pmdp_pkg::*;

  typedef struct packed {
    logic [7:0] mask_byte;
    logic [7:0] data_byte;
    logic       row_end;
  } byte_pair_t;

  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 200;

  // palette index per 3-bit colour, orange at 8; already decremented
  localparam logic [IDX_W-1:0] PALETTE_IDX [NUM_COLOURS] = '{
    3'd0, 3'd2, 3'd0, 3'd5, 3'd3, 3'd6, 3'd1, 3'd4, 3'd7
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [PHASE_W-1:0]      cfg_wr_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    m_tlast;

  pixel_t     pixel_q[$];
  byte_pair_t pair_q[$];

  logic [7:0]         mask_acc;
  logic [7:0]         data_acc;
  logic [PHASE_W-1:0] phase_cnt;
  logic [PHASE_W-1:0] row_shift;

  pace_t tx_pace = PACE_FULL;
  pace_t rx_pace = PACE_FULL;
  int    errors = 0;
  int    cycle_count = 0;

  pixel_mask_data_packer_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [IDX_W-1:0] palette_index(input pixel_t p);
    logic [COL_W-1:0] col;
    if (!p.inside_image) begin
      return '0;
    end
    col = {1'b0, p.red >= CHAN_THRESH, p.green >= CHAN_THRESH, p.blue >= CHAN_THRESH};
    if (col == COL_YELLOW && p.green < ORANGE_GREEN) begin
      col = COL_ORANGE;
    end
    return PALETTE_IDX[col];
  endfunction

  task automatic restart_row();
    mask_acc  = MASK_INIT;
    data_acc  = DATA_INIT;
    phase_cnt = row_shift;
  endtask

  task automatic pack_pixel(input pixel_t p);
    logic [IDX_W-1:0] idx;
    logic             bit_in;
    int               fill;
    byte_pair_t       pr;
    idx    = palette_index(p);
    bit_in = phase_cnt[0] ? idx[0] : idx[1];
    mask_acc = mask_acc << 1;
    data_acc = {data_acc[6:0], bit_in};
    if (phase_cnt == PHASE_LAST) begin
      phase_cnt = '0;
      pr = '{mask_acc, data_acc, p.row_last};
      pair_q.push_back(pr);
      if (p.row_last) begin
        restart_row();
      end
    end else begin
      phase_cnt = phase_cnt + 1'b1;
      if (p.row_last) begin
        // pad the partial byte: data with zeros, mask with ones
        fill = 8 - int'(phase_cnt);
        data_acc = data_acc << fill;
        mask_acc = (mask_acc << fill) | (8'hff >> phase_cnt);
        pr = '{mask_acc, data_acc, 1'b1};
        pair_q.push_back(pr);
        restart_row();
      end
    end
  endtask

  // pixel driver
  always @(posedge clk) begin : pixel_driver
    int     burst_left;
    int     gap_left;
    pixel_t nxt;
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      row_shift  = '0;
      restart_row();
    end else begin
      if (s_tvalid && s_tready) begin
        pack_pixel(pixel_t'({s_tlast, s_tdata[24:0]}));
      end
      if (!s_tvalid || s_tready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          case (tx_pace)
            PACE_FULL:  gap_left = 0;
            PACE_LIGHT: gap_left = $urandom_range(0, 3);
            default:    gap_left = $urandom_range(1, 12);
          endcase
        end
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          burst_left--;
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TDATA_W'(nxt[24:0]);
          s_tlast  <= nxt.row_last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : pair_monitor
    byte_pair_t want;
    int         stall_left;
    logic       ready_nxt;
    if (rst) begin
      stall_left = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pair_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual mask=%h data=%h row_end=%b",
                   $time, m_tdata[7:0], m_tdata[15:8], m_tlast);
          errors++;
        end else begin
          want = pair_q.pop_front();
          if (m_tdata[7:0] !== want.mask_byte) begin
            $display("%0t: mask_byte expected %h actual %h", $time, want.mask_byte, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[15:8] !== want.data_byte) begin
            $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                     m_tdata[15:8]);
            errors++;
          end
          if (m_tlast !== want.row_end) begin
            $display("%0t: row_end expected %b actual %b", $time, want.row_end, m_tlast);
            errors++;
          end
        end
      end
      ready_nxt = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else if (rx_pace == PACE_LIGHT && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 2);
        ready_nxt  = 1'b0;
      end else if (rx_pace == PACE_HEAVY && $urandom_range(0, 4) < 2) begin
        stall_left = $urandom_range(0, 15);
        ready_nxt  = 1'b0;
      end
      m_tready <= ready_nxt;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pixel_mask_data_packer_top regression: fail");
      $finish;
    end
  end

  function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic in_img,
                                        input logic last);
    pixel_t p;
    p.red          = r;
    p.green        = g;
    p.blue         = b;
    p.inside_image = in_img;
    p.row_last     = last;
    return p;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd223;
      5:       return 8'd224;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic wait_drained();
    while (pixel_q.size() != 0 || s_tvalid || pair_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_shift(input logic [PHASE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    row_shift   = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // rows of random length; the last row may be left open
  task automatic queue_random_rows(input int count);
    int n;
    int len;
    int sel;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) len = $urandom_range(1, 16);
      else if (sel < 19) len = $urandom_range(17, 48);
      else len = $urandom_range(49, 120);
      for (int i = 0; i < len && n < count; i++) begin
        pixel_q.push_back(make_pixel(rand_channel(), rand_channel(), rand_channel(),
                                     $urandom_range(0, 9) != 0, i == len - 1));
        n++;
      end
    end
  endtask

  initial begin : stimulus
    logic [PHASE_W-1:0] shift_plan [RAND_PHASES];
    pace_t              tx_plan [RAND_PHASES];
    pace_t              rx_plan [RAND_PHASES];
    shift_plan = '{3'd7, 3'd0, PHASE_W'($urandom_range(0, 7)), 3'd3, 3'd7,
                   PHASE_W'($urandom_range(0, 7))};
    tx_plan = '{PACE_FULL, PACE_HEAVY, PACE_LIGHT, pace_t'($urandom_range(0, 2)),
                PACE_HEAVY, pace_t'($urandom_range(0, 2))};
    rx_plan = '{PACE_FULL, PACE_HEAVY, PACE_HEAVY, pace_t'($urandom_range(0, 2)),
                PACE_LIGHT, pace_t'($urandom_range(0, 2))};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all eight colors, byte completes on the row's last pixel
    for (int c = 0; c < 8; c++) begin
      pixel_q.push_back(make_pixel(c[2] ? 8'd255 : 8'd0, c[1] ? 8'd255 : 8'd0,
                                   c[0] ? 8'd255 : 8'd0, 1'b1, c == 7));
    end
    // orange vs yellow, thresholds, outside pixel; byte mid-row then padded tail
    pixel_q.push_back(make_pixel(8'd255, 8'd223, 8'd0, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd128, 8'd224, 8'd127, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd127, 8'd127, 8'd127, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd128, 8'd128, 8'd128, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
    pixel_q.push_back(make_pixel(8'd255, 8'd0, 8'd255, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd0, 8'd255, 8'd255, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd255, 8'd128, 8'd0, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd128, 8'd128, 8'd0, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd255, 8'd255, 8'd0, 1'b1, 1'b1));
    // single-pixel row, then an open row
    pixel_q.push_back(make_pixel(8'd0, 8'd0, 8'd255, 1'b1, 1'b1));
    pixel_q.push_back(make_pixel(8'd255, 8'd224, 8'd0, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd0, 8'd255, 8'd0, 1'b1, 1'b0));
    wait_drained();

    // start shift written mid-row: applies from the next row
    write_start_shift(3'd5);
    pixel_q.push_back(make_pixel(8'd255, 8'd0, 8'd0, 1'b1, 1'b0));
    pixel_q.push_back(make_pixel(8'd0, 8'd128, 8'd255, 1'b1, 1'b1));
    for (int i = 0; i < 4; i++) begin
      pixel_q.push_back(make_pixel(8'd255, 8'd255, 8'd128, 1'b1, i == 3));
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      write_start_shift(shift_plan[ph]);
      tx_pace = tx_plan[ph];
      rx_pace = rx_plan[ph];
      queue_random_rows(PHASE_ITEMS);
    end
    wait_drained();

    if (errors == 0) begin
      $display("pixel_mask_data_packer_top regression: pass");
    end else begin
      $display("pixel_mask_data_packer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== pixel_mask_data_packer_top.f =====
design/pmdp_pkg.sv
design/pmdp_in_stage.sv
design/pmdp_index.sv
design/pmdp_pack.sv
design/pixel_mask_data_packer_top.sv
design/pmdp_checker.sv
dv/testbench.sv
